/* hdl/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg: shared constants of the pulse rate tachometer
// Register indexes, register reset values and the rate scale factor.
// ----------------------------------------------------------------------------
package prt_pkg;

  // scale from pulses per tick to pulses per minute at one tick per ms
  localparam int          SCALE_W    = 16;
  localparam logic [15:0] RATE_SCALE = 16'd60000;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_TIMEOUT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STABLE_RATE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_TICKS   = 3'd6;

  localparam logic        RST_ENABLE          = 1'b1;
  localparam logic [15:0] RST_WINDOW_TICKS    = 16'd1000;
  localparam logic [15:0] RST_MIN_RATE        = 16'd50;
  localparam logic [15:0] RST_MAX_RATE        = 16'd5000;
  localparam logic [15:0] RST_SIGNAL_TIMEOUT  = 16'd2000;
  localparam logic [15:0] RST_MIN_STABLE_RATE = 16'd100;
  localparam logic [7:0]  RST_LOCKOUT_TICKS   = 8'd10;

endpackage

/* hdl/prt_div.sv */
// ----------------------------------------------------------------------------
// prt_div: serial rate divider
// Computes pulses * 60000 / elapsed: a multiply state, then a restoring
// divide that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prt_div #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [COUNT_WIDTH-1:0]                  pulses,
  input  logic [COUNT_WIDTH-1:0]                  elapsed,
  output logic                                    done,
  output logic [COUNT_WIDTH+prt_pkg::SCALE_W-1:0] quotient
);

  localparam int QW     = COUNT_WIDTH + prt_pkg::SCALE_W;
  localparam int STEP_W = $clog2(QW + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;

  logic [1:0]             state;
  logic [COUNT_WIDTH-1:0] pulses_q;
  logic [COUNT_WIDTH-1:0] divisor;
  logic [QW-1:0]          quot;
  logic [COUNT_WIDTH:0]   rem;
  logic [STEP_W-1:0]      step;

  logic [COUNT_WIDTH:0]   rem_shift;
  logic                   fits;

  assign rem_shift = {rem[COUNT_WIDTH-1:0], quot[QW-1]};
  assign fits      = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            pulses_q <= pulses;
            divisor  <= elapsed;
            state    <= D_MUL;
          end
        end
        D_MUL: begin
          quot  <= QW'(pulses_q) * QW'(prt_pkg::RATE_SCALE);
          rem   <= '0;
          step  <= STEP_W'(QW);
          state <= D_DIV;
        end
        D_DIV: begin
          if (fits) begin
            rem  <= rem_shift - {1'b0, divisor};
            quot <= {quot[QW-2:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            quot <= {quot[QW-2:0], 1'b0};
          end
          step <= step - 1'b1;
          if (step == STEP_W'(1)) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign quotient = quot;

endmodule

/* hdl/pulse_rate_tachometer.sv */
// ----------------------------------------------------------------------------
// pulse_rate_tachometer: gated window tachometer
// One beat per millisecond tick; counts debounced pulses over a window and
// turns the count into pulses per minute with a serial divider.
// ----------------------------------------------------------------------------
// flow: a tick passes S_DONE, or S_CALC and then S_DONE when it closes a
//   window with pulses and the divider runs; in_stall holds off new ticks
//   until the result beat of the current one is loaded
// reset: registers take their defaults, counters and rate clear, no result held
module pulse_rate_tachometer #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            pulse_edge,
  input  logic                            clear,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     rate_rpm,
  output logic                            receiving,
  output logic                            signal_valid,
  output logic                            window_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  localparam int QW    = COUNT_WIDTH + prt_pkg::SCALE_W;
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // configuration registers
  logic        enable;
  logic [15:0] window_ticks;
  logic [15:0] min_rate;
  logic [15:0] max_rate;
  logic [15:0] signal_timeout;
  logic [15:0] min_stable_rate;
  logic [7:0]  lockout_ticks;

  // measurement state
  logic [1:0]             state;
  logic [COUNT_WIDTH-1:0] ticks_since_pulse;
  logic [COUNT_WIDTH-1:0] window_pulses;
  logic [COUNT_WIDTH-1:0] window_elapsed;
  logic [15:0]            rate_value;
  logic                   done_flag;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] ticks_inc;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic [COUNT_WIDTH-1:0] pulses_inc;
  logic                   take_pulse;
  logic [COUNT_WIDTH-1:0] ticks_next;
  logic [COUNT_WIDTH-1:0] pulses_next;
  logic                   window_close;
  logic                   div_start;
  logic                   div_done;
  logic [QW-1:0]          div_quot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= prt_pkg::RST_ENABLE;
      window_ticks    <= prt_pkg::RST_WINDOW_TICKS;
      min_rate        <= prt_pkg::RST_MIN_RATE;
      max_rate        <= prt_pkg::RST_MAX_RATE;
      signal_timeout  <= prt_pkg::RST_SIGNAL_TIMEOUT;
      min_stable_rate <= prt_pkg::RST_MIN_STABLE_RATE;
      lockout_ticks   <= prt_pkg::RST_LOCKOUT_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prt_pkg::REG_ENABLE:          enable          <= cfg_data[0];
        prt_pkg::REG_WINDOW_TICKS:    window_ticks    <= cfg_data;
        prt_pkg::REG_MIN_RATE:        min_rate        <= cfg_data;
        prt_pkg::REG_MAX_RATE:        max_rate        <= cfg_data;
        prt_pkg::REG_SIGNAL_TIMEOUT:  signal_timeout  <= cfg_data;
        prt_pkg::REG_MIN_STABLE_RATE: min_stable_rate <= cfg_data;
        prt_pkg::REG_LOCKOUT_TICKS:   lockout_ticks   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // timers advance first, then the lockout test, then the window test
  always_comb begin
    ticks_inc    = (ticks_since_pulse == CNT_MAX) ? ticks_since_pulse
                                                  : ticks_since_pulse + 1'b1;
    elapsed_inc  = (window_elapsed == CNT_MAX) ? window_elapsed : window_elapsed + 1'b1;
    pulses_inc   = (window_pulses == CNT_MAX) ? window_pulses : window_pulses + 1'b1;
    take_pulse   = pulse_edge && (CMP_W'(ticks_inc) > CMP_W'(lockout_ticks));
    ticks_next   = take_pulse ? '0 : ticks_inc;
    pulses_next  = take_pulse ? pulses_inc : window_pulses;
    window_close = (CMP_W'(elapsed_inc) >= CMP_W'(window_ticks))
                   || (elapsed_inc == CNT_MAX);
  end

  assign div_start = accept && !clear && enable && window_close && (pulses_next != '0);

  prt_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .pulses   (pulses_next),
    .elapsed  (elapsed_inc),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      ticks_since_pulse <= '0;
      window_pulses     <= '0;
      window_elapsed    <= '0;
      rate_value        <= '0;
      done_flag         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (clear || !enable) begin
              ticks_since_pulse <= '0;
              window_pulses     <= '0;
              window_elapsed    <= '0;
              rate_value        <= '0;
              done_flag         <= 1'b0;
              state             <= S_DONE;
            end else begin
              ticks_since_pulse <= ticks_next;
              done_flag         <= window_close;
              if (window_close) begin
                window_pulses  <= '0;
                window_elapsed <= '0;
                if (pulses_next == '0 && CMP_W'(ticks_next) > CMP_W'(signal_timeout)) begin
                  rate_value <= '0;
                end
              end else begin
                window_pulses  <= pulses_next;
                window_elapsed <= elapsed_inc;
              end
              state <= div_start ? S_CALC : S_DONE;
            end
          end
        end
        S_CALC: begin
          if (div_done) begin
            priority if (div_quot < QW'(min_rate)) begin
              rate_value <= '0;
            end else if (div_quot > QW'(max_rate)) begin
              // out of range, old rate kept
            end else begin
              rate_value <= div_quot[15:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat, loaded when leaving S_DONE
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      rate_rpm     <= rate_value;
      receiving    <= CMP_W'(ticks_since_pulse) < CMP_W'(signal_timeout);
      signal_valid <= (CMP_W'(ticks_since_pulse) < CMP_W'(signal_timeout))
                      && (rate_value >= min_stable_rate);
      window_done  <= done_flag;
    end
  end

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("new tick taken while previous still in work");

  a_div_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_CALC))
    else $error("divider finished outside rate calculation");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result beat raised without finished tick");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && done_flag) |-> (window_elapsed == '0 && window_pulses == '0))
    else $error("window counters not cleared on window close");

endmodule

/* dv/pulse_rate_tachometer_tb.sv */
// ----------------------------------------------------------------------------
// pulse_rate_tachometer_tb: self-checking bench of the pulse rate tachometer
// Feeds millisecond tick beats with pulse and clear flags under random idling
// and back-pressure. A tick-level model of the tachometer predicts each
// reading, and every reading is checked field by field. Covers directed rate
// cases, a long window with a timeout and randomized register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_rate_tachometer_tb;

  localparam int                              CNT_W        = 16;
  localparam logic [CNT_W-1:0]                CNT_TOP      = '1;
  localparam longint unsigned                 RPM_PER_TICK = 60000;
  localparam int                              CYCLE_LIMIT  = 2000000;
  localparam logic [prt_pkg::CFG_INDEX_W-1:0] REG_SPARE    = '1;

  typedef struct packed {
    bit pulse;
    bit clr;
  } tick_item_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic        recv;
    logic        sig_ok;
    logic        done;
  } reading_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            pulse_edge = 1'b0;
  logic                            clear = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [15:0]                     rate_rpm;
  logic                            receiving;
  logic                            signal_valid;
  logic                            window_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [prt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]                     cfg_data = '0;

  pulse_rate_tachometer #(.COUNT_WIDTH(CNT_W)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pulse_edge(pulse_edge), .clear(clear),
    .out_valid(out_valid), .out_stall(out_stall),
    .rate_rpm(rate_rpm), .receiving(receiving),
    .signal_valid(signal_valid), .window_done(window_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // register copies
  bit          cfg_en       = prt_pkg::RST_ENABLE;
  logic [15:0] cfg_window   = prt_pkg::RST_WINDOW_TICKS;
  logic [15:0] cfg_min_rate = prt_pkg::RST_MIN_RATE;
  logic [15:0] cfg_max_rate = prt_pkg::RST_MAX_RATE;
  logic [15:0] cfg_timeout  = prt_pkg::RST_SIGNAL_TIMEOUT;
  logic [15:0] cfg_stable   = prt_pkg::RST_MIN_STABLE_RATE;
  logic [7:0]  cfg_lockout  = prt_pkg::RST_LOCKOUT_TICKS;

  // tachometer state
  logic [CNT_W-1:0] ticks_idle  = '0;
  logic [CNT_W-1:0] win_pulses  = '0;
  logic [CNT_W-1:0] win_elapsed = '0;
  logic [15:0]      held_rpm    = '0;

  tick_item_t tick_q[$];
  reading_t   pending_readings[$];
  tick_item_t drive_item;

  int  ticks_pushed = 0;
  int  ticks_taken  = 0;
  int  errors       = 0;
  int  cycle_cnt    = 0;
  int  gap_left     = 0;
  int  hold_left    = 0;
  bit  in_took      = 1'b0;
  bit  out_took     = 1'b0;
  bit  in_calm      = 1'b0;
  bit  out_calm     = 1'b0;
  bit  rush         = 1'b0;

  function automatic void apply_reg(logic [prt_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
    case (idx)
      prt_pkg::REG_ENABLE:          cfg_en       = data[0];
      prt_pkg::REG_WINDOW_TICKS:    cfg_window   = data;
      prt_pkg::REG_MIN_RATE:        cfg_min_rate = data;
      prt_pkg::REG_MAX_RATE:        cfg_max_rate = data;
      prt_pkg::REG_SIGNAL_TIMEOUT:  cfg_timeout  = data;
      prt_pkg::REG_MIN_STABLE_RATE: cfg_stable   = data;
      prt_pkg::REG_LOCKOUT_TICKS:   cfg_lockout  = data[7:0];
      default: ;
    endcase
  endfunction

  // one millisecond tick of the tachometer
  function automatic reading_t tach_step(bit pulse, bit clr);
    reading_t        o;
    longint unsigned quot;
    o.done = 1'b0;
    if (clr || !cfg_en) begin
      ticks_idle  = '0;
      win_pulses  = '0;
      win_elapsed = '0;
      held_rpm    = '0;
    end else begin
      if (ticks_idle != CNT_TOP) ticks_idle++;
      if (win_elapsed != CNT_TOP) win_elapsed++;
      if (pulse && ticks_idle > cfg_lockout) begin
        if (win_pulses != CNT_TOP) win_pulses++;
        ticks_idle = '0;
      end
      if (win_elapsed >= cfg_window || win_elapsed == CNT_TOP) begin
        if (win_pulses != 0) begin
          quot = (64'(win_pulses) * RPM_PER_TICK) / 64'(win_elapsed);
          if (quot < 64'(cfg_min_rate)) begin
            held_rpm = '0;
          end else if (quot <= 64'(cfg_max_rate)) begin
            held_rpm = quot[15:0];
          end
        end else if (ticks_idle > cfg_timeout) begin
          held_rpm = '0;
        end
        win_pulses  = '0;
        win_elapsed = '0;
        o.done = 1'b1;
      end
    end
    o.recv   = ticks_idle < cfg_timeout;
    o.sig_ok = o.recv && held_rpm >= cfg_stable;
    o.rpm    = held_rpm;
    return o;
  endfunction

  function automatic logic [15:0] pick_reg(int lo, int hi);
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic push_tick(bit pulse, bit clr);
    tick_item_t it;
    it.pulse = pulse;
    it.clr   = clr;
    tick_q.push_back(it);
    ticks_pushed++;
  endtask

  task automatic drain();
    while (ticks_taken != ticks_pushed || pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [prt_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] en_data, logic [15:0] window, logic [15:0] min_r,
                            logic [15:0] max_r, logic [15:0] timeout, logic [15:0] stable,
                            logic [15:0] lock_data);
    drain();
    write_reg(prt_pkg::REG_ENABLE, en_data);
    write_reg(prt_pkg::REG_WINDOW_TICKS, window);
    write_reg(prt_pkg::REG_MIN_RATE, min_r);
    write_reg(prt_pkg::REG_MAX_RATE, max_r);
    write_reg(prt_pkg::REG_SIGNAL_TIMEOUT, timeout);
    write_reg(prt_pkg::REG_MIN_STABLE_RATE, stable);
    write_reg(prt_pkg::REG_LOCKOUT_TICKS, lock_data);
    @(posedge clk);
  endtask

  // tick driver
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        drive_item = tick_q.pop_front();
        pulse_edge <= drive_item.pulse;
        clear      <= drive_item.clr;
        in_valid   <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap_left = (rush || in_calm) ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reading back-pressure
  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      hold_left = (rush || out_calm) ? 0 : $urandom_range(0, 11);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    reading_t want;
    in_took  = !rst && in_valid && !in_stall;
    out_took = !rst && out_valid && !out_stall;
    if (in_took) begin
      pending_readings.push_back(tach_step(pulse_edge, clear));
      ticks_taken++;
    end
    if (out_took) begin
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected beat: rate_rpm %0d receiving %0b signal_valid %0b window_done %0b",
                 $time, rate_rpm, receiving, signal_valid, window_done);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (rate_rpm !== want.rpm) begin
          $display("%0t rate_rpm: expected %0d actual %0d", $time, want.rpm, rate_rpm);
          errors++;
        end
        if (receiving !== want.recv) begin
          $display("%0t receiving: expected %0b actual %0b", $time, want.recv, receiving);
          errors++;
        end
        if (signal_valid !== want.sig_ok) begin
          $display("%0t signal_valid: expected %0b actual %0b", $time, want.sig_ok,
                   signal_valid);
          errors++;
        end
        if (window_done !== want.done) begin
          $display("%0t window_done: expected %0b actual %0b", $time, want.done, window_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [19:0] burst;
    logic [15:0] min_r;
    logic [15:0] max_r;
    logic [7:0]  lock;
    int          period;
    burst = 20'b1111_1010_0000_0000_1000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // writes to an unmapped index are dropped
    write_reg(REG_SPARE, 16'hffff);

    // 4 tick window, no lockout: too fast, in range, kept, timed out, too slow
    set_config(16'h0001, 16'd4, 16'd20000, 16'd40000, 16'd5, 16'd30000, 16'h0000);
    for (int i = 19; i >= 0; i--) push_tick(burst[i], 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);

    // disabled, upper data bits set
    set_config(16'hfffe, 16'd4, 16'd0, 16'd65535, 16'd3, 16'd0, 16'hff00);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);

    // pulse every tick over a long window, then silence past the timeout
    set_config(16'h0001, 16'd300, 16'd0, 16'hffff, 16'd200, 16'd60000, 16'h0000);
    rush = 1'b1;
    repeat (300) push_tick(1'b1, 1'b0);
    repeat (400) push_tick(1'b0, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      min_r = pick_reg(0, 30000);
      if ($urandom_range(0, 3) != 0) max_r = 16'(min_r + $urandom_range(0, 65535 - min_r));
      else max_r = pick_reg(0, 65535);
      period = $urandom_range(1, 15);
      case ($urandom_range(0, 7))
        0:       lock = 8'hff;
        1:       lock = 8'h00;
        default: lock = 8'($urandom_range(0, period + 2));
      endcase
      set_config({15'($urandom), 1'($urandom_range(0, 9) != 0)}, pick_reg(1, 40), min_r,
                 max_r, pick_reg(0, 60), pick_reg(0, 40000), {8'($urandom), lock});
      rush = 1'b0;
      for (int i = 0; i < 200; i++) begin
        push_tick((i % period == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0),
                  $urandom_range(0, 149) == 0);
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
